@@ hw/rtl/aes128_pkg.sv @@
// ----------------------------------------------------------------------------
// aes128_pkg
// shared types, s-box table and round helpers for the aes-128 encrypt core
// ----------------------------------------------------------------------------
package aes128_pkg;

    localparam int NumRounds = 10;
    localparam int AddrWidth = 4;

    localparam logic [AddrWidth-1:0] RegKeyHigh = 4'h0;
    localparam logic [AddrWidth-1:0] RegKeyLow  = 4'h8;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } plain_beat_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_beat_t;

    typedef logic [127:0] block_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // byte i of a block sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(block_t b, int i);
        return b[127 - 8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // next round key from the previous one
    function automatic block_t next_key(block_t k, logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // subbytes and shiftrows
    function automatic block_t sub_shift(block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                   a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
        end
        return t;
    endfunction

endpackage

@@ hw/rtl/aes128_block_encrypt_core.sv @@
// ----------------------------------------------------------------------------
// aes128_block_encrypt_core
// fully unrolled aes-128 encryption pipeline with apb key registers
// ----------------------------------------------------------------------------
// usage:
//   a plaintext beat is taken on any clock edge with start high; busy is
//   always low, so a new block may enter every cycle
//   the ciphertext beat appears on result with done high for one cycle,
//   after the block has passed one stage for the initial key add, then
//   one stage per round, each with its own round-key step
//   throughput is one block per clock, set by the ten round stages
//   the key lives in two 64-bit apb registers (key_high at 0x0, key_low at
//   0x8) and travels down the pipe with each block, so a key write only
//   touches blocks taken after it
//   reset clears the valid bits and both key registers
//   the receiver cannot stall; results are never held back
// ----------------------------------------------------------------------------
module aes128_block_encrypt_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  aes128_pkg::plain_beat_t   plain,
    output logic                      done,
    output aes128_pkg::cipher_beat_t  result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);
    import aes128_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    logic        wr_en;

    // pipe: index 0 is the initial add round key stage
    logic   valid_pipe [NumRounds+1];
    block_t state_pipe [NumRounds+1];
    block_t key_pipe   [NumRounds+1];

    logic   valid0_reg;
    block_t state0_reg, key0_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                RegKeyHigh: key_high_reg <= pwdata;
                RegKeyLow:  key_low_reg  <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            RegKeyHigh: prdata = key_high_reg;
            RegKeyLow:  prdata = key_low_reg;
            default:    prdata = '0;
        endcase
    end

    // entry stage: initial round key add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        state0_reg <= {plain.plain_high, plain.plain_low} ^ {key_high_reg, key_low_reg};
        key0_reg   <= {key_high_reg, key_low_reg};
    end

    assign valid_pipe[0] = valid0_reg;
    assign state_pipe[0] = state0_reg;
    assign key_pipe[0]   = key0_reg;

    for (genvar r = 1; r <= NumRounds; r++)
    begin : g_round
        aes128_round #(.Round(r)) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_pipe[r-1]),
            .state_in  (state_pipe[r-1]),
            .key_in    (key_pipe[r-1]),
            .valid_out (valid_pipe[r]),
            .state_out (state_pipe[r]),
            .key_out   (key_pipe[r])
        );
    end

    assign done               = valid_pipe[NumRounds];
    assign result.cipher_high = state_pipe[NumRounds][127:64];
    assign result.cipher_low  = state_pipe[NumRounds][63:0];
endmodule

@@ hw/rtl/aes128_round.sv @@
// ----------------------------------------------------------------------------
// aes128_round
// one registered cipher round with its own on-the-fly key expansion step
// ----------------------------------------------------------------------------
module aes128_round #(
    parameter int Round = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  aes128_pkg::block_t  state_in,
    input  aes128_pkg::block_t  key_in,
    output logic                valid_out,
    output aes128_pkg::block_t  state_out,
    output aes128_pkg::block_t  key_out
);
    import aes128_pkg::*;

    logic   valid_reg;
    block_t state_reg, state_next;
    block_t key_reg, key_next;

    always_comb
    begin
        key_next = next_key(key_in, RCON[Round-1]);
        if (Round == NumRounds)
        begin
            state_next = sub_shift(state_in) ^ key_next;
        end
        else
        begin
            state_next = mix_columns(sub_shift(state_in)) ^ key_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
endmodule

@@ hw/rtl/aes128_checker.sv @@
// ----------------------------------------------------------------------------
// aes128_checker
// port-level checks on the encrypt core, bound to the top level
// ----------------------------------------------------------------------------
module aes128_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);
    // every accepted beat comes out as a result beat with done high
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##11 done)
        else $error("missing result beat");

    // no result without a matching accepted beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 11))
        else $error("spurious result beat");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind aes128_block_encrypt_core aes128_checker u_aes128_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);
